### rtl/core/rgbhsl_pkg.sv
// Shared constants, register indexes and types of the RGB to HSL/HSV/HSI unit.
package rgbhsl_pkg;

    localparam int HUE_FRACTION_BITS_DEF = 16;

    // Divider operand width: the hue divisor 6*(max-min) needs 11 bits.
    localparam int DIV_W = 11;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REF_HUE     = 2'd0,
        CFG_REF_IS_GRAY = 2'd1,
        CFG_HUE_TOL     = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] HUE_TOL_RESET = 16'd3277;

    // Fields that travel beside the dividers unchanged.
    typedef struct packed {
        logic       gray;
        logic [8:0] lsum;
        logic [9:0] isum;
        logic [7:0] mx;
    } t_side;

endpackage

### rtl/core/rgb_to_hsl_hsv_hsi_with_hue_match_unit.sv
// Top level of the RGB to HSL/HSV/HSI converter with hue match.
//
// Pixels enter on the slave stream (tdata: red, green, blue, 8 bits each from
// the lowest bit up) and one result leaves on the master stream per pixel.
// Configuration goes through a plain write port: i_cfg_we with register index
// i_cfg_addr (0 reference hue, 1 reference is gray, 2 hue tolerance) and data
// i_cfg_wdata, taken at the clock edge.
// The pipeline runs through the min/max register, the operand register, QW
// stages of the four restoring dividers (one quotient bit per stage), and the
// output register, with QW = max(16, HUE_FRACTION_BITS + 1).
// Throughput is one pixel per clock while the output is not stalled; the divider
// pipeline accepts a new operand set every cycle in which the pipeline advances.
// The whole pipeline advances on one enable: when the output register holds a
// result that is not taken, every stage holds and o_s_axis_tready is low, so
// nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline and sets the registers
// to reference hue 0, colored reference and tolerance 3277.
module rgb_to_hsl_hsv_hsi_with_hue_match_unit
    import rgbhsl_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [23:0]           i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // is_gray [0], hue [16:1], hsl_saturation [32:17], lightness_sum [41:33],
    // hsi_saturation [57:42], intensity_sum [67:58], hsv_saturation [83:68],
    // hsv_value [91:84], hue_match [92], zero [95:93]
    output logic [95:0]           o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int H  = HUE_FRACTION_BITS;
    localparam int QW = (H + 1 > 16) ? H + 1 : 16;
    localparam int EW = ((H > 16) ? H : 16) + 2;
    localparam int NV = QW + 3;

    logic        en;
    logic [NV-1:0] r_vld;

    logic [15:0] r_ref_hue;
    logic        r_ref_gray;
    logic [15:0] r_tol;

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_hue  <= '0;
            r_ref_gray <= 1'b0;
            r_tol      <= HUE_TOL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_REF_HUE:     r_ref_hue  <= i_cfg_wdata;
                CFG_REF_IS_GRAY: r_ref_gray <= i_cfg_wdata[0];
                CFG_HUE_TOL:     r_tol      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 1: max, min, sum and hue sector.
    logic [7:0] in_r, in_g, in_b, n_mx, n_mn;
    logic       n_rsec, n_gsec;
    logic [7:0] r1_r, r1_g, r1_b, r1_mx, r1_mn;
    logic [9:0] r1_sum;
    logic       r1_rsec, r1_gsec;

    assign in_r = i_s_axis_tdata[7:0];
    assign in_g = i_s_axis_tdata[15:8];
    assign in_b = i_s_axis_tdata[23:16];

    always_comb begin
        n_mx = in_r;
        n_mn = in_r;
        if (in_g > n_mx) n_mx = in_g;
        if (in_b > n_mx) n_mx = in_b;
        if (in_g < n_mn) n_mn = in_g;
        if (in_b < n_mn) n_mn = in_b;
        n_rsec = (in_r == n_mx);
        n_gsec = !n_rsec && (in_g == n_mx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_r    <= in_r;
            r1_g    <= in_g;
            r1_b    <= in_b;
            r1_mx   <= n_mx;
            r1_mn   <= n_mn;
            r1_sum  <= 10'(in_r) + 10'(in_g) + 10'(in_b);
            r1_rsec <= n_rsec;
            r1_gsec <= n_gsec;
        end
    end

    // Stage 2: divider operands.
    logic [7:0]       d;
    logic [8:0]       lsum;
    logic [DIV_W-1:0] n_hnum, n_hden, n_lden;
    logic [DIV_W-1:0] r2_hnum, r2_hden, r2_lnum, r2_lden, r2_inum, r2_iden, r2_vden;
    t_side            r2_side;

    assign d    = r1_mx - r1_mn;
    assign lsum = 9'(r1_mx) + 9'(r1_mn);

    always_comb begin
        n_hden = 11'(d) * 11'd6;
        if (r1_rsec) begin
            if (r1_g >= r1_b) n_hnum = 11'(r1_g) - 11'(r1_b);
            else              n_hnum = n_hden + 11'(r1_g) - 11'(r1_b);
        end else if (r1_gsec) begin
            n_hnum = 11'(r1_b) + {2'b0, d, 1'b0} - 11'(r1_r);
        end else begin
            n_hnum = 11'(r1_r) + {1'b0, d, 2'b0} - 11'(r1_g);
        end
        // HSL divides by 2 - max - min in the upper half of lightness.
        if (lsum <= 9'd255) n_lden = 11'(lsum);
        else                n_lden = 11'd510 - 11'(lsum);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_hnum      <= n_hnum;
            r2_hden      <= n_hden;
            r2_lnum      <= 11'(d);
            r2_lden      <= n_lden;
            r2_inum      <= 11'(r1_sum) - 11'(r1_mn) * 11'd3;
            r2_iden      <= 11'(r1_sum);
            r2_vden      <= 11'(r1_mx);
            r2_side.gray <= (d == 8'd0);
            r2_side.lsum <= lsum;
            r2_side.isum <= r1_sum;
            r2_side.mx   <= r1_mx;
        end
    end

    // Divider stages.
    logic [QW-1:0] q_hue, q_hsl, q_hsi, q_hsv;

    rgbhsl_div #(.QW(QW), .DW(DIV_W)) u_div_hue (
        .i_clk(i_clk), .i_en(en), .i_num(r2_hnum), .i_den(r2_hden), .o_quo(q_hue)
    );
    rgbhsl_div #(.QW(QW), .DW(DIV_W)) u_div_hsl (
        .i_clk(i_clk), .i_en(en), .i_num(r2_lnum), .i_den(r2_lden), .o_quo(q_hsl)
    );
    rgbhsl_div #(.QW(QW), .DW(DIV_W)) u_div_hsi (
        .i_clk(i_clk), .i_en(en), .i_num(r2_inum), .i_den(r2_iden), .o_quo(q_hsi)
    );
    rgbhsl_div #(.QW(QW), .DW(DIV_W)) u_div_hsv (
        .i_clk(i_clk), .i_en(en), .i_num(r2_vden == '0 ? '0 : r2_lnum),
        .i_den(r2_vden), .o_quo(q_hsv)
    );

    t_side r_side [QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r2_side;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output stage: scaling, gray handling and hue match.
    t_side         sd;
    logic [H-1:0]  hue_full;
    logic [EW-1:0] test, ref_m, tol, turn;
    logic [15:0]   hue_o, hsl_o, hsi_o, hsv_o;
    logic          in_range, match;

    assign sd       = r_side[QW-1];
    assign hue_full = sd.gray ? '0 : q_hue[QW-2 -: H];
    assign test     = EW'(hue_full);
    assign turn     = EW'(1) << H;
    assign ref_m    = EW'(r_ref_hue) & (turn - EW'(1));
    assign tol      = EW'(r_tol);
    assign hue_o    = test[15:0];
    assign hsl_o    = sd.gray ? '0 : q_hsl[QW-1 -: 16];
    assign hsi_o    = sd.gray ? '0 : q_hsi[QW-1 -: 16];
    assign hsv_o    = sd.gray ? '0 : q_hsv[QW-1 -: 16];

    always_comb begin
        if (ref_m < tol) begin
            in_range = (test < ref_m + tol) || (test + tol > turn + ref_m);
        end else if (ref_m + tol > turn) begin
            in_range = (test > ref_m - tol) || (test + turn < ref_m + tol);
        end else begin
            in_range = (test + tol > ref_m) && (test < ref_m + tol);
        end
        if (sd.gray)        match = r_ref_gray;
        else if (r_ref_gray) match = 1'b0;
        else                match = in_range;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_axis_tdata <= {3'b000, match, sd.mx, hsv_o, sd.isum, hsi_o, sd.lsum,
                               hsl_o, hue_o, sd.gray};
        end
    end

endmodule

### rtl/core/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, for a dividend not above the divisor.
module rgbhsl_div
    import rgbhsl_pkg::*;
#(
    parameter int QW = 16,
    parameter int DW = DIV_W
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          qbit;

        if (k == 0) begin : g_first
            // The first step yields the integer bit, so no doubling.
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign t      = {1'b0, rem_in};
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign t      = {rem_in, 1'b0};
        end

        assign diff = t - {1'b0, den_in};
        assign qbit = (t >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= qbit ? diff[DW-1:0] : t[DW-1:0];
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[QW-2:0], qbit};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
